// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AIP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define AIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AIP_ASSERT(label, clk, rst_n, prop)
`define AIP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/aip_pkg.sv -----
// ----------------------------------------------------------------------------
// aip_pkg
// Types and constants shared by the ASCII integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package aip_pkg;

    localparam int VALUE_WIDTH  = 32;
    localparam int RESULT_WIDTH = 32;
    localparam int CHAR_WIDTH   = 8;
    localparam int DIGIT_WIDTH  = 4;
    localparam int RADIX_COUNT  = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CHAR_X       = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CHAR_B       = 8'h62;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CASE_FOLD    = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] LETTER_BASE  = 8'd17;
    localparam logic [CHAR_WIDTH-1:0] LETTER_GAP   = 8'd7;
    localparam logic [CHAR_WIDTH-1:0] DIGIT_MAX    = 8'd9;

    typedef enum logic [1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_DEC = 2'd2,
        RADIX_HEX = 2'd3
    } radix_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEAD   = 3'd1,
        PH_SIGNED = 3'd2,
        PH_ZERO   = 3'd3,
        PH_DIGITS = 3'd4
    } phase_t;

    typedef struct packed {
        logic                   start;
        logic                   is_space;
        logic                   is_term;
        logic                   is_minus;
        logic                   is_zero;
        logic                   is_dec;
        logic                   is_x;
        logic                   is_b;
        logic [RADIX_COUNT-1:0] radix_ok;
        logic [DIGIT_WIDTH-1:0] digit;
    } char_class_t;

    function automatic logic [CHAR_WIDTH-1:0] radix_value(input radix_t r);
        logic [CHAR_WIDTH-1:0] v;
        begin
            case (r)
                RADIX_BIN: v = 8'd2;
                RADIX_OCT: v = 8'd8;
                RADIX_DEC: v = 8'd10;
                RADIX_HEX: v = 8'd16;
                default:   v = 8'd10;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/aip_char_if.sv -----
// ----------------------------------------------------------------------------
// aip_char_if
// Character channel: one ASCII character and its start mark per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface aip_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       start_flag;

    modport source (output valid, output char_code, output start_flag, input ready);
    modport sink   (input valid, input char_code, input start_flag, output ready);
endinterface

`default_nettype wire

// ----- design/aip_result_if.sv -----
// ----------------------------------------------------------------------------
// aip_result_if
// Result channel: one parsed value and its error flag per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface aip_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] parsed_value;
    logic               parse_error;

    modport source (output valid, output parsed_value, output parse_error, input ready);
    modport sink   (input valid, input parsed_value, input parse_error, output ready);
endinterface

`default_nettype wire

// ----- design/ascii_integer_parser_unit.sv -----
// ----------------------------------------------------------------------------
// ascii_integer_parser_unit
// Streaming ASCII-to-integer parser with 0x / 0b / 0 radix prefixes.
// ----------------------------------------------------------------------------
// Takes one character per transfer and sustains one character per clock. A
// character is classified on acceptance, held in a two-entry queue and taken
// from its register by the parse engine, whose single shift-add accumulator
// step per character sets the rate; the output register takes a result when
// the engine pops the character that ends the number. The engine stalls only
// while a finished result waits to be taken and the queue holds up to two
// characters in that time. Values wrap modulo 2^VALUE_WIDTH and are returned
// sign-extended or truncated to 32 bits; errors return zero.
`default_nettype none

module ascii_integer_parser_unit #(
    parameter int VALUE_WIDTH = aip_pkg::VALUE_WIDTH
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    aip_char_if.sink     chars,
    aip_result_if.source results
);

    logic                 q_push;
    logic                 q_ready;
    logic                 q_valid;
    logic                 q_pop;
    aip_pkg::char_class_t push_entry;
    aip_pkg::char_class_t pop_entry;

    aip_front u_front (
        .chars   (chars),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    aip_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .ready      (q_ready),
        .pop_valid  (q_valid),
        .pop_entry  (pop_entry),
        .pop        (q_pop)
    );

    aip_engine #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (pop_entry),
        .q_pop   (q_pop),
        .results (results)
    );

endmodule

`default_nettype wire

// ----- design/aip_front.sv -----
// ----------------------------------------------------------------------------
// aip_front
// Accepts characters and classifies them for the parse engine.
// ----------------------------------------------------------------------------
`default_nettype none

module aip_front (
    aip_char_if.sink             chars,
    input  wire logic            q_ready,
    output logic                 q_push,
    output aip_pkg::char_class_t q_entry
);

    localparam int CW = aip_pkg::CHAR_WIDTH;

    logic [CW-1:0] c;
    logic [CW-1:0] folded;
    logic [CW-1:0] d0;
    logic [CW-1:0] d1;
    logic          above_letters;
    logic          letter_bad;

    assign c = chars.char_code;
    assign chars.ready = q_ready;
    assign q_push = chars.valid && q_ready;

    always_comb
    begin
        folded        = (c >= aip_pkg::CHAR_LOWER_A) ? c - aip_pkg::CASE_FOLD : c;
        d0            = folded - aip_pkg::CHAR_ZERO;
        above_letters = (d0 >= aip_pkg::LETTER_BASE);
        d1            = above_letters ? d0 - aip_pkg::LETTER_GAP : d0;
        letter_bad    = above_letters && (d1 <= aip_pkg::DIGIT_MAX);

        q_entry.start    = chars.start_flag;
        q_entry.is_space = (c == aip_pkg::CHAR_SPACE);
        q_entry.is_term  = (c <= aip_pkg::CHAR_SPACE);
        q_entry.is_minus = (c == aip_pkg::CHAR_MINUS);
        q_entry.is_zero  = (c == aip_pkg::CHAR_ZERO);
        q_entry.is_dec   = (c >= aip_pkg::CHAR_ZERO) && (c <= aip_pkg::CHAR_NINE);
        q_entry.is_x     = (c == aip_pkg::CHAR_X);
        q_entry.is_b     = (c == aip_pkg::CHAR_B);
        q_entry.digit    = d1[aip_pkg::DIGIT_WIDTH-1:0];
        for (int k = 0; k < aip_pkg::RADIX_COUNT; k++)
        begin
            q_entry.radix_ok[k] = !letter_bad &&
                (d1 < aip_pkg::radix_value(aip_pkg::radix_t'(k)));
        end
    end

endmodule

`default_nettype wire

// ----- design/aip_queue.sv -----
// ----------------------------------------------------------------------------
// aip_queue
// Short register queue of classified characters between front and engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module aip_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire aip_pkg::char_class_t push_entry,
    output logic                      ready,
    output logic                      pop_valid,
    output aip_pkg::char_class_t      pop_entry,
    input  wire logic                 pop
);

    localparam int DEPTH = aip_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aip_pkg::char_class_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        begin
            return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        end
    endfunction

    assign ready     = (count_reg != CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `AIP_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `AIP_ASSERT(a_pop_nonempty, clk, rst_n, !(pop && count_reg == '0))
    `AIP_ASSERT_NEXT(a_push_only_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

`default_nettype wire

// ----- design/aip_engine.sv -----
// ----------------------------------------------------------------------------
// aip_engine
// Parse state machine, accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module aip_engine #(
    parameter int VALUE_WIDTH = aip_pkg::VALUE_WIDTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire aip_pkg::char_class_t q_entry,
    output logic                      q_pop,
    aip_result_if.source              results
);

    localparam int VW = VALUE_WIDTH;
    localparam int RW = aip_pkg::RESULT_WIDTH;
    localparam int DW = aip_pkg::DIGIT_WIDTH;

    aip_pkg::phase_t phase_reg, phase_next, phase_cur;
    aip_pkg::radix_t radix_reg, radix_next, radix_cur;
    logic            negative_reg, negative_next, negative_cur;
    logic [VW-1:0]   acc_reg, acc_next, acc_cur, acc_step;
    logic [VW-1:0]   digit_ext;
    logic            advance;
    logic            emit;
    logic            emit_error;
    logic [VW-1:0]   emit_value;
    logic signed [VW-1:0] emit_signed;

    logic                 out_valid_reg, out_valid_next;
    logic signed [RW-1:0] out_value_reg;
    logic                 out_error_reg;

    assign advance = q_valid && (!out_valid_reg || results.ready);
    assign q_pop   = advance;

    assign phase_cur    = q_entry.start ? aip_pkg::PH_LEAD : phase_reg;
    assign radix_cur    = q_entry.start ? aip_pkg::RADIX_BIN : radix_reg;
    assign negative_cur = q_entry.start ? 1'b0 : negative_reg;
    assign acc_cur      = q_entry.start ? '0 : acc_reg;
    assign digit_ext    = VW'(q_entry.digit);

    always_comb
    begin
        case (radix_cur)
            aip_pkg::RADIX_BIN: acc_step = (acc_cur << 1) + digit_ext;
            aip_pkg::RADIX_OCT: acc_step = (acc_cur << 3) + digit_ext;
            aip_pkg::RADIX_DEC: acc_step = (acc_cur << 3) + (acc_cur << 1) + digit_ext;
            aip_pkg::RADIX_HEX: acc_step = (acc_cur << 4) + digit_ext;
            default:            acc_step = acc_cur;
        endcase
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            case (phase_cur)
                aip_pkg::PH_LEAD:
                begin
                    if (q_entry.is_space)      phase_next = aip_pkg::PH_LEAD;
                    else if (q_entry.is_minus) phase_next = aip_pkg::PH_SIGNED;
                    else if (q_entry.is_zero)  phase_next = aip_pkg::PH_ZERO;
                    else if (q_entry.is_dec)   phase_next = aip_pkg::PH_DIGITS;
                    else                       phase_next = aip_pkg::PH_IDLE;
                end
                aip_pkg::PH_SIGNED:
                begin
                    if (q_entry.is_zero)       phase_next = aip_pkg::PH_ZERO;
                    else if (q_entry.is_dec)   phase_next = aip_pkg::PH_DIGITS;
                    else                       phase_next = aip_pkg::PH_IDLE;
                end
                aip_pkg::PH_ZERO:
                begin
                    if (q_entry.is_x || q_entry.is_b)          phase_next = aip_pkg::PH_DIGITS;
                    else if (q_entry.is_term)                  phase_next = aip_pkg::PH_IDLE;
                    else if (q_entry.radix_ok[aip_pkg::RADIX_OCT])
                                                               phase_next = aip_pkg::PH_DIGITS;
                    else                                       phase_next = aip_pkg::PH_IDLE;
                end
                aip_pkg::PH_DIGITS:
                begin
                    if (q_entry.is_term)                       phase_next = aip_pkg::PH_IDLE;
                    else if (q_entry.radix_ok[radix_cur])      phase_next = aip_pkg::PH_DIGITS;
                    else                                       phase_next = aip_pkg::PH_IDLE;
                end
                default: phase_next = aip_pkg::PH_IDLE;
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        radix_next    = radix_cur;
        negative_next = negative_cur;
        acc_next      = acc_cur;
        emit          = 1'b0;
        emit_error    = 1'b0;
        emit_value    = '0;
        case (phase_cur)
            aip_pkg::PH_LEAD, aip_pkg::PH_SIGNED:
            begin
                if (phase_cur == aip_pkg::PH_LEAD && q_entry.is_space)
                begin
                end
                else if (phase_cur == aip_pkg::PH_LEAD && q_entry.is_minus)
                begin
                    negative_next = 1'b1;
                end
                else if (q_entry.is_zero)
                begin
                end
                else if (q_entry.is_dec)
                begin
                    radix_next = aip_pkg::RADIX_DEC;
                    acc_next   = digit_ext;
                end
                else
                begin
                    emit       = 1'b1;
                    emit_error = 1'b1;
                end
            end
            aip_pkg::PH_ZERO:
            begin
                if (q_entry.is_x)
                begin
                    radix_next = aip_pkg::RADIX_HEX;
                    acc_next   = '0;
                end
                else if (q_entry.is_b)
                begin
                    radix_next = aip_pkg::RADIX_BIN;
                    acc_next   = '0;
                end
                else if (q_entry.is_term)
                begin
                    emit = 1'b1;
                end
                else if (q_entry.radix_ok[aip_pkg::RADIX_OCT])
                begin
                    radix_next = aip_pkg::RADIX_OCT;
                    acc_next   = digit_ext;
                end
                else
                begin
                    emit       = 1'b1;
                    emit_error = 1'b1;
                end
            end
            aip_pkg::PH_DIGITS:
            begin
                if (q_entry.is_term)
                begin
                    emit       = 1'b1;
                    emit_value = negative_cur ? -acc_cur : acc_cur;
                end
                else if (q_entry.radix_ok[radix_cur])
                begin
                    acc_next = acc_step;
                end
                else
                begin
                    emit       = 1'b1;
                    emit_error = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign emit_signed    = emit_value;
    assign out_valid_next = (advance && emit) ? 1'b1 :
                            (results.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= aip_pkg::PH_IDLE;
            radix_reg     <= aip_pkg::RADIX_BIN;
            negative_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                radix_reg    <= radix_next;
                negative_reg <= negative_next;
                acc_reg      <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_value_reg <= RW'(emit_signed);
            out_error_reg <= emit_error;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.parsed_value = out_value_reg;
    assign results.parse_error  = out_error_reg;

    `AIP_ASSERT(a_error_is_zero, clk, rst_n, !(out_valid_reg && out_error_reg && out_value_reg != '0))
    `AIP_ASSERT_NEXT(a_emit_goes_idle, clk, rst_n, advance && emit, phase_reg == aip_pkg::PH_IDLE)
    `AIP_ASSERT(a_no_pop_on_stall, clk, rst_n, !(q_pop && out_valid_reg && !results.ready))

endmodule

`default_nettype wire

// ----- dv/tb_ascii_integer_parser_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ascii_integer_parser_unit
// Self-checking bench for the streaming ASCII integer parser.
// ----------------------------------------------------------------------------
// Walks a short table of hand-picked strings, then sends random number strings
// in every radix with random prefixes, signs, terminators and injected faults,
// mixed with raw byte noise. An in-bench parser model predicts each result;
// results are checked in order, field by field. Both sides idle in bursts.

module tb_ascii_integer_parser_unit;

    localparam int VW             = aip_pkg::VALUE_WIDTH;
    localparam int ITEM_GOAL      = 1000;
    localparam int CALM_TAIL      = 150;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DIR_ROWS       = 27;
    localparam int RADIX_BASE [4] = '{2, 8, 10, 16};
    localparam logic [4:0] NOT_DIGIT = 5'h1F;

    typedef struct packed {
        logic signed [31:0] value;
        logic               err;
    } outcome_t;

    typedef struct packed {
        logic [7:0]         chr;
        logic               sop;
        logic               typed;
        logic signed [31:0] value;
        logic               err;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    aip_char_if   ch();
    aip_result_if rs();

    ascii_integer_parser_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (ch),
        .results (rs)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser model state
    aip_pkg::phase_t ph  = aip_pkg::PH_IDLE;
    aip_pkg::radix_t rdx = aip_pkg::RADIX_BIN;
    logic            neg = 1'b0;
    logic [VW-1:0]   acc = '0;

    outcome_t pending_results [$];
    int       live_items   = 0;
    int       fail_count   = 0;
    int       quiet_cycles = 0;
    bit       gap_on       = 1'b1;
    bit       stall_on     = 1'b1;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{"Z",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"0",   1'b1, 1'b0, 32'sd0, 1'b0},
        '{" ",   1'b0, 1'b1, 32'sd0, 1'b0},
        '{"-",   1'b1, 1'b0, 32'sd0, 1'b0},
        '{"0",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"x",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 32'sd0, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 32'sd0, 1'b1},
        '{"-",   1'b1, 1'b0, 32'sd0, 1'b0},
        '{" ",   1'b0, 1'b1, 32'sd0, 1'b1},
        '{" ",   1'b1, 1'b0, 32'sd0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 32'sd0, 1'b1},
        '{"0",   1'b1, 1'b0, 32'sd0, 1'b0},
        '{"8",   1'b0, 1'b1, 32'sd0, 1'b1},
        '{"Q",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"0",   1'b1, 1'b0, 32'sd0, 1'b0},
        '{"x",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{":",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{" ",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"0",   1'b1, 1'b0, 32'sd0, 1'b0},
        '{"b",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"1",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{8'h1F, 1'b0, 1'b0, 32'sd0, 1'b0},
        '{"1",   1'b1, 1'b0, 32'sd0, 1'b0},
        '{"2",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"7",   1'b1, 1'b0, 32'sd0, 1'b0},
        '{8'h0A, 1'b0, 1'b0, 32'sd0, 1'b0}
    };

    function automatic logic [4:0] digit_of(input logic [7:0] c, input int base);
        logic [7:0] d;
        d = c;
        if (d >= aip_pkg::CHAR_LOWER_A)
            d = d - aip_pkg::CASE_FOLD;
        d = d - aip_pkg::CHAR_ZERO;
        if (d >= aip_pkg::LETTER_BASE)
        begin
            d = d - aip_pkg::LETTER_GAP;
            if (d <= aip_pkg::DIGIT_MAX)
                return NOT_DIGIT;
        end
        if (int'(d) >= base)
            return NOT_DIGIT;
        return d[4:0];
    endfunction

    function automatic bit finish_number(input logic [VW-1:0] v, input logic err,
                                         output outcome_t res);
        logic signed [VW-1:0] sv;
        logic signed [63:0]   wide;
        sv        = err ? '0 : v;
        wide      = sv;
        res.value = wide[31:0];
        res.err   = err;
        ph        = aip_pkg::PH_IDLE;
        return 1'b1;
    endfunction

    function automatic bit first_digit(input logic [7:0] c, output outcome_t res);
        res = '0;
        if (c == aip_pkg::CHAR_ZERO)
        begin
            ph = aip_pkg::PH_ZERO;
            return 1'b0;
        end
        if (c < aip_pkg::CHAR_ZERO || c > aip_pkg::CHAR_NINE)
            return finish_number('0, 1'b1, res);
        rdx = aip_pkg::RADIX_DEC;
        acc = VW'(c - aip_pkg::CHAR_ZERO);
        ph  = aip_pkg::PH_DIGITS;
        return 1'b0;
    endfunction

    // Advances the parser model by one character; returns 1 when a result is due.
    function automatic bit parse_char(input logic [7:0] c, input logic sop,
                                      output outcome_t res);
        logic [4:0] d;
        bit         done;
        done = 1'b0;
        res  = '0;
        if (sop)
        begin
            ph  = aip_pkg::PH_LEAD;
            rdx = aip_pkg::RADIX_BIN;
            neg = 1'b0;
            acc = '0;
        end
        case (ph)
            aip_pkg::PH_LEAD:
            begin
                if (c == aip_pkg::CHAR_MINUS)
                begin
                    neg = 1'b1;
                    ph  = aip_pkg::PH_SIGNED;
                end
                else if (c != aip_pkg::CHAR_SPACE)
                    done = first_digit(c, res);
            end
            aip_pkg::PH_SIGNED:
                done = first_digit(c, res);
            aip_pkg::PH_ZERO:
            begin
                if (c == aip_pkg::CHAR_X || c == aip_pkg::CHAR_B)
                begin
                    rdx = (c == aip_pkg::CHAR_X) ? aip_pkg::RADIX_HEX : aip_pkg::RADIX_BIN;
                    acc = '0;
                    ph  = aip_pkg::PH_DIGITS;
                end
                else if (c <= aip_pkg::CHAR_SPACE)
                    done = finish_number('0, 1'b0, res);
                else if (c < aip_pkg::CHAR_ZERO || c > aip_pkg::CHAR_NINE)
                    done = finish_number('0, 1'b1, res);
                else
                begin
                    rdx = aip_pkg::RADIX_OCT;
                    d   = digit_of(c, RADIX_BASE[aip_pkg::RADIX_OCT]);
                    if (d == NOT_DIGIT)
                        done = finish_number('0, 1'b1, res);
                    else
                    begin
                        acc = VW'(d);
                        ph  = aip_pkg::PH_DIGITS;
                    end
                end
            end
            aip_pkg::PH_DIGITS:
            begin
                if (c <= aip_pkg::CHAR_SPACE)
                    done = finish_number(neg ? -acc : acc, 1'b0, res);
                else
                begin
                    d = digit_of(c, RADIX_BASE[rdx]);
                    if (d == NOT_DIGIT)
                        done = finish_number('0, 1'b1, res);
                    else
                        acc = acc * VW'(RADIX_BASE[rdx]) + VW'(d);
                end
            end
            default:
                ph = aip_pkg::PH_IDLE;
        endcase
        return done;
    endfunction

    task automatic report(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    // Drives one character and returns in the step of its transfer, valid still high.
    task automatic push_char(input logic [7:0] c, input logic sop, input logic typed,
                             input logic signed [31:0] tv, input logic te);
        outcome_t res;
        if (gap_on && $urandom_range(0, 4) == 0)
        begin
            ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        ch.valid      <= 1'b1;
        ch.char_code  <= c;
        ch.start_flag <= sop;
        do
            @(posedge clk);
        while (!ch.ready);
        if (sop || ph != aip_pkg::PH_IDLE)
            live_items++;
        if (parse_char(c, sop, res) || typed)
        begin
            if (typed)
            begin
                res.value = tv;
                res.err   = te;
            end
            pending_results.push_back(res);
        end
    endtask

    task automatic drain_results();
        ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            push_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, '0, 1'b0);
    endtask

    task automatic send_number();
        logic [7:0] txt [$];
        logic [7:0] c;
        int         v;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                repeat ($urandom_range(0, 2)) txt.push_back(aip_pkg::CHAR_SPACE);
                if ($urandom_range(0, 2) == 0) txt.push_back(aip_pkg::CHAR_MINUS);
                txt.push_back(8'(aip_pkg::CHAR_ZERO + $urandom_range(1, 9)));
                repeat ($urandom_range(0, 11))
                    txt.push_back(8'(aip_pkg::CHAR_ZERO + $urandom_range(0, 9)));
            end
            2:
            begin
                if ($urandom_range(0, 2) == 0) txt.push_back(aip_pkg::CHAR_MINUS);
                txt.push_back(aip_pkg::CHAR_ZERO);
                txt.push_back(aip_pkg::CHAR_X);
                repeat ($urandom_range(0, 10))
                begin
                    v = $urandom_range(0, 15);
                    if ($urandom_range(0, 19) == 0)
                        c = 8'(aip_pkg::CHAR_NINE + $urandom_range(1, 6));
                    else if (v < 10)
                        c = 8'(aip_pkg::CHAR_ZERO + v);
                    else if ($urandom_range(0, 1) == 0)
                        c = 8'(aip_pkg::CHAR_LOWER_A + v - 10);
                    else
                        c = 8'(aip_pkg::CHAR_LOWER_A - aip_pkg::CASE_FOLD + v - 10);
                    txt.push_back(c);
                end
            end
            3:
            begin
                if ($urandom_range(0, 2) == 0) txt.push_back(aip_pkg::CHAR_MINUS);
                txt.push_back(aip_pkg::CHAR_ZERO);
                txt.push_back(aip_pkg::CHAR_B);
                repeat ($urandom_range(0, 36))
                    txt.push_back(8'(aip_pkg::CHAR_ZERO + $urandom_range(0, 1)));
            end
            4:
            begin
                if ($urandom_range(0, 2) == 0) txt.push_back(aip_pkg::CHAR_MINUS);
                txt.push_back(aip_pkg::CHAR_ZERO);
                repeat ($urandom_range(1, 12))
                    txt.push_back(8'(aip_pkg::CHAR_ZERO + $urandom_range(0, 7)));
            end
            default:
            begin
                if ($urandom_range(0, 1) == 0) txt.push_back(aip_pkg::CHAR_MINUS);
                txt.push_back(aip_pkg::CHAR_ZERO);
                v = $urandom_range(0, 2);
                if (v == 1) txt.push_back(aip_pkg::CHAR_X);
                if (v == 2) txt.push_back(aip_pkg::CHAR_B);
            end
        endcase
        // broken strings: a stray byte, or no terminator
        if ($urandom_range(0, 5) == 0)
            txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) != 0)
            txt.push_back(8'($urandom_range(0, 32)));
        foreach (txt[i])
            push_char(txt[i], i == 0, 1'b0, '0, 1'b0);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                push_char(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0, 1'b0);
    endtask

    initial
    begin : sink_side
        int stall_left;
        stall_left = 0;
        rs.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    rs.ready <= 1'b1;
            end
            else if (stall_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 9);
                rs.ready <= 1'b0;
            end
            else
                rs.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && rs.valid && rs.ready)
        begin
            if (pending_results.size() == 0)
                report($sformatf("unexpected result value=%0d err=%0b",
                                 rs.parsed_value, rs.parse_error));
            else
            begin
                want = pending_results.pop_front();
                if (rs.parsed_value !== want.value || rs.parse_error !== want.err)
                    report($sformatf("mismatch: expected value=%0d err=%0b, got value=%0d err=%0b",
                                     want.value, want.err, rs.parsed_value, rs.parse_error));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((ch.valid && ch.ready) || (rs.valid && rs.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        bit held;
        held = 1'b0;
        rst_n         <= 1'b0;
        ch.valid      <= 1'b0;
        ch.char_code  <= '0;
        ch.start_flag <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            push_char(dir_tab[i].chr, dir_tab[i].sop, dir_tab[i].typed,
                      dir_tab[i].value, dir_tab[i].err);
        drain_results();

        while (live_items < ITEM_GOAL)
        begin
            if (live_items >= ITEM_GOAL - CALM_TAIL)
            begin
                gap_on   = 1'b0;
                stall_on = 1'b0;
            end
            else if ($urandom_range(0, 29) == 0)
            begin
                gap_on   = $urandom_range(0, 2) != 0;
                stall_on = $urandom_range(0, 2) != 0;
            end
            if (!held && live_items >= ITEM_GOAL / 2)
            begin
                held = 1'b1;
                drain_results();
            end
            if ($urandom_range(0, 7) == 0)
                send_noise();
            else
                send_number();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/aip_pkg.sv
design/aip_char_if.sv
design/aip_result_if.sv
design/aip_front.sv
design/aip_queue.sv
design/aip_engine.sv
design/ascii_integer_parser_unit.sv
dv/tb_ascii_integer_parser_unit.sv
